// File: hdl/mfilt_pkg.sv
`default_nettype none

package mfilt_pkg;

    // configuration port
    localparam int CFG_W     = 11;
    localparam int CFG_IDX_W = 1;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_FRAME_WIDTH  = 1'b0,
        REG_FRAME_HEIGHT = 1'b1
    } mfilt_reg_e;

    localparam logic [CFG_W-1:0] WIDTH_RESET  = 11'd640;
    localparam logic [CFG_W-1:0] HEIGHT_RESET = 11'd480;
    localparam logic [CFG_W-1:0] HEIGHT_LIMIT = 11'd1024;

    // row counter covers rows 0..HEIGHT_LIMIT-1
    localparam int ROW_W = 10;

    // per-pixel flags that travel with the window down the pipeline
    typedef struct packed {
        logic window_valid;
        logic frame_done;
    } mfilt_tag_t;

endpackage

`default_nettype wire

// File: hdl/mfilt_ram.sv
`default_nettype none

module mfilt_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // read-first: a read of the address being written returns the old word
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// File: hdl/mfilt_rank.sv
`default_nettype none

module mfilt_rank
    import mfilt_pkg::*;
#(
    parameter int TAPS       = 9,
    parameter int PIXEL_BITS = 8
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       in_valid,
    output logic                            in_ready,
    input  wire logic [TAPS*PIXEL_BITS-1:0] in_win,
    input  wire mfilt_tag_t                 in_tag,
    output logic                            out_valid,
    input  wire logic                       out_ready,
    output logic      [PIXEL_BITS-1:0]      median,
    output mfilt_tag_t                      out_tag
);

    localparam int RANK_W = $clog2(TAPS + 1);
    localparam int MID    = TAPS / 2;

    // compare stage
    logic                  a_valid_reg;
    mfilt_tag_t            a_tag_reg;
    logic [PIXEL_BITS-1:0] a_val_reg [TAPS];
    logic [TAPS-1:0]       a_before_reg [TAPS];
    logic [TAPS-1:0]       before_next [TAPS];
    logic                  a_ready;

    // rank stage
    logic                  b_valid_reg;
    mfilt_tag_t            b_tag_reg;
    logic [PIXEL_BITS-1:0] b_val_reg [TAPS];
    logic [TAPS-1:0]       b_sel_reg;
    logic [TAPS-1:0]       sel_next;
    logic                  b_ready;

    // output register
    logic                  o_valid_reg;
    mfilt_tag_t            o_tag_reg;
    logic [PIXEL_BITS-1:0] o_median_reg;
    logic [PIXEL_BITS-1:0] median_next;
    logic                  o_ready;

    assign o_ready  = !o_valid_reg || out_ready;
    assign b_ready  = !b_valid_reg || o_ready;
    assign a_ready  = !a_valid_reg || b_ready;
    assign in_ready = a_ready;

    // element j is ordered ahead of element i (ties broken by position)
    always_comb
    begin
        for (int i = 0; i < TAPS; i++)
        begin
            for (int j = 0; j < TAPS; j++)
            begin
                before_next[i][j] =
                    (in_win[j*PIXEL_BITS +: PIXEL_BITS] < in_win[i*PIXEL_BITS +: PIXEL_BITS]) ||
                    ((in_win[j*PIXEL_BITS +: PIXEL_BITS] == in_win[i*PIXEL_BITS +: PIXEL_BITS])
                     && (j < i));
            end
        end
    end

    // the element with exactly MID predecessors is the median
    always_comb
    begin
        logic [RANK_W-1:0] cnt;
        for (int i = 0; i < TAPS; i++)
        begin
            cnt = '0;
            for (int j = 0; j < TAPS; j++)
            begin
                cnt = cnt + RANK_W'(a_before_reg[i][j]);
            end
            sel_next[i] = (cnt == RANK_W'(MID));
        end
    end

    always_comb
    begin
        median_next = '0;
        for (int i = 0; i < TAPS; i++)
        begin
            median_next = median_next | (b_val_reg[i] & {PIXEL_BITS{b_sel_reg[i]}});
        end
        // border pixels report zero
        if (!b_tag_reg.window_valid)
        begin
            median_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            o_valid_reg <= 1'b0;
        end
        else
        begin
            if (a_ready)
            begin
                a_valid_reg <= in_valid;
            end
            if (b_ready)
            begin
                b_valid_reg <= a_valid_reg;
            end
            if (o_ready)
            begin
                o_valid_reg <= b_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (a_ready && in_valid)
        begin
            a_tag_reg <= in_tag;
            for (int i = 0; i < TAPS; i++)
            begin
                a_val_reg[i]    <= in_win[i*PIXEL_BITS +: PIXEL_BITS];
                a_before_reg[i] <= before_next[i];
            end
        end
        if (b_ready && a_valid_reg)
        begin
            b_tag_reg <= a_tag_reg;
            b_sel_reg <= sel_next;
            for (int i = 0; i < TAPS; i++)
            begin
                b_val_reg[i] <= a_val_reg[i];
            end
        end
        if (o_ready && b_valid_reg)
        begin
            o_tag_reg    <= b_tag_reg;
            o_median_reg <= median_next;
        end
    end

    assign out_valid = o_valid_reg;
    assign median    = o_median_reg;
    assign out_tag   = o_tag_reg;

endmodule

`default_nettype wire

// File: hdl/median_filter_3x3.sv
// path: an accepted pixel passes stage 1, the window register and the rank stages to the output
// throughput: one pixel per clock unless the output stalls; the line memory does one read and
//   one write-back per pixel, with the write-back forwarded when the next pixel hits the same column
// reset: counters and pipeline valids clear, window clears, geometry returns to 640x480
// the line memory is not cleared; entries hold whatever was last written
`default_nettype none

module median_filter_3x3
    import mfilt_pkg::*;
#(
    parameter int WINDOW     = 3,
    parameter int MAX_WIDTH  = 1024,
    parameter int PIXEL_BITS = 8
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    // pixel input
    input  wire logic                  in_valid,
    output logic                       in_ready,
    input  wire logic [PIXEL_BITS-1:0] pixel,
    // result output
    output logic                       out_valid,
    input  wire logic                  out_ready,
    output logic      [PIXEL_BITS-1:0] median,
    output logic                       window_valid,
    output logic                       frame_done,
    // configuration writes
    input  wire logic                  cfg_valid,
    output logic                       cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_W-1:0]      cfg_data
);

    localparam int LINES  = WINDOW - 1;
    localparam int TAPS   = WINDOW * WINDOW;
    localparam int COL_W  = $clog2(MAX_WIDTH);
    localparam int WORD_W = LINES * PIXEL_BITS;
    // compare width that holds both the column count plus one and the width register
    localparam int CMP_W  = (COL_W + 1 > CFG_W) ? COL_W + 1 : CFG_W;

    localparam logic [CMP_W-1:0] MAXW = CMP_W'(MAX_WIDTH);

    // geometry registers
    logic [CFG_W-1:0] width_reg;
    logic [CFG_W-1:0] height_reg;

    // raster position of the next pixel
    logic [COL_W-1:0] col_reg;
    logic [ROW_W-1:0] row_reg;

    logic [CMP_W-1:0] eff_w;
    logic [CFG_W-1:0] eff_h;
    logic [CMP_W-1:0] col_plus;
    logic [CFG_W-1:0] row_plus;
    logic             col_last;
    logic             row_last;
    logic             win_ok;
    logic             in_fire;

    // stage 1: line memory read data arrives, column is built and written back
    logic                  s1_valid_reg;
    logic [PIXEL_BITS-1:0] s1_px_reg;
    logic [COL_W-1:0]      s1_addr_reg;
    mfilt_tag_t            s1_tag_reg;
    logic                  s1_fwd_reg;
    logic [WORD_W-1:0]     fwd_word_reg;
    logic                  s1_ready;
    logic                  s1_adv;

    logic [WORD_W-1:0]     ram_rdata;
    logic [WORD_W-1:0]     old_word;
    logic [WORD_W-1:0]     new_word;
    logic [PIXEL_BITS-1:0] newcol [WINDOW];

    // stage 2: the window itself
    logic                  s2_valid_reg;
    mfilt_tag_t            s2_tag_reg;
    logic [PIXEL_BITS-1:0] win_reg [TAPS];
    logic [TAPS*PIXEL_BITS-1:0] win_flat;
    logic                  s2_ready;
    logic                  rank_ready;
    mfilt_tag_t            out_tag;

    assign cfg_ready = 1'b1;

    // configuration decode
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= WIDTH_RESET;
            height_reg <= HEIGHT_RESET;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_FRAME_WIDTH:  width_reg  <= cfg_data;
                REG_FRAME_HEIGHT: height_reg <= cfg_data;
            endcase
        end
    end

    // saturate geometry: width to 1..MAX_WIDTH, height to 1..HEIGHT_LIMIT
    always_comb
    begin
        eff_w = CMP_W'(width_reg);
        if (eff_w == '0)
        begin
            eff_w = CMP_W'(1);
        end
        else if (eff_w > MAXW)
        begin
            eff_w = MAXW;
        end

        eff_h = height_reg;
        if (eff_h == '0)
        begin
            eff_h = CFG_W'(1);
        end
        else if (eff_h > HEIGHT_LIMIT)
        begin
            eff_h = HEIGHT_LIMIT;
        end
    end

    assign col_plus = CMP_W'(col_reg) + CMP_W'(1);
    assign row_plus = CFG_W'(row_reg) + CFG_W'(1);
    assign col_last = (col_plus >= eff_w);
    assign row_last = (row_plus >= eff_h);
    assign win_ok   = (col_reg >= COL_W'(WINDOW - 1)) && (row_reg >= ROW_W'(WINDOW - 1));

    assign in_ready = s1_ready;
    assign in_fire  = in_valid && s1_ready;

    // raster counters advance per accepted pixel
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= '0;
        end
        else if (in_fire)
        begin
            if (col_last)
            begin
                col_reg <= '0;
                row_reg <= row_last ? '0 : ROW_W'(row_plus);
            end
            else
            begin
                col_reg <= COL_W'(col_plus);
            end
        end
    end

    // one word per column holds every line, oldest line in the top slot
    mfilt_ram #(
        .WIDTH (WORD_W),
        .DEPTH (MAX_WIDTH)
    ) u_line_ram (
        .clk   (clk),
        .we    (s1_adv),
        .waddr (s1_addr_reg),
        .wdata (new_word),
        .re    (in_fire),
        .raddr (col_reg),
        .rdata (ram_rdata)
    );

    assign s1_adv   = s1_valid_reg && s2_ready;
    assign s1_ready = !s1_valid_reg || s1_adv;

    // a same-column write-back lands on the edge that read it, so take it from the bypass
    assign old_word = s1_fwd_reg ? fwd_word_reg : ram_rdata;

    always_comb
    begin
        // age the lines at this column, new pixel becomes the newest line
        new_word[0 +: PIXEL_BITS] = s1_px_reg;
        for (int k = 1; k < LINES; k++)
        begin
            new_word[k*PIXEL_BITS +: PIXEL_BITS] = old_word[(k-1)*PIXEL_BITS +: PIXEL_BITS];
        end
        // entering column: oldest line on top, new pixel at the bottom
        for (int k = 0; k < LINES; k++)
        begin
            newcol[WINDOW-2-k] = old_word[k*PIXEL_BITS +: PIXEL_BITS];
        end
        newcol[WINDOW-1] = s1_px_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s1_fwd_reg   <= 1'b0;
        end
        else if (s1_ready)
        begin
            s1_valid_reg <= in_valid;
            if (in_valid)
            begin
                s1_fwd_reg <= s1_adv && (s1_addr_reg == col_reg);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            s1_px_reg                <= pixel;
            s1_addr_reg              <= col_reg;
            s1_tag_reg.window_valid  <= win_ok;
            s1_tag_reg.frame_done    <= col_last && row_last;
            fwd_word_reg             <= new_word;
        end
    end

    // window shifts left one column per pixel, new column on the right
    assign s2_ready = !s2_valid_reg || rank_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
            for (int i = 0; i < TAPS; i++)
            begin
                win_reg[i] <= '0;
            end
        end
        else
        begin
            if (s2_ready)
            begin
                s2_valid_reg <= s1_valid_reg;
            end
            if (s1_adv)
            begin
                for (int r = 0; r < WINDOW; r++)
                begin
                    for (int c = 0; c < WINDOW - 1; c++)
                    begin
                        win_reg[r*WINDOW + c] <= win_reg[r*WINDOW + c + 1];
                    end
                    win_reg[r*WINDOW + WINDOW - 1] <= newcol[r];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_adv)
        begin
            s2_tag_reg <= s1_tag_reg;
        end
    end

    always_comb
    begin
        for (int i = 0; i < TAPS; i++)
        begin
            win_flat[i*PIXEL_BITS +: PIXEL_BITS] = win_reg[i];
        end
    end

    // rank-select median, three stages including the output register
    mfilt_rank #(
        .TAPS       (TAPS),
        .PIXEL_BITS (PIXEL_BITS)
    ) u_rank (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s2_valid_reg),
        .in_ready  (rank_ready),
        .in_win    (win_flat),
        .in_tag    (s2_tag_reg),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .median    (median),
        .out_tag   (out_tag)
    );

    assign window_valid = out_tag.window_valid;
    assign frame_done   = out_tag.frame_done;

endmodule

`default_nettype wire

// File: hdl/mfilt_checker.sv
`default_nettype none

module mfilt_checker #(
    parameter int PIXEL_BITS = 8
) (
    input wire logic                  clk,
    input wire logic                  rst_n,
    input wire logic                  in_valid,
    input wire logic                  in_ready,
    input wire logic                  out_valid,
    input wire logic                  out_ready,
    input wire logic [PIXEL_BITS-1:0] median,
    input wire logic                  window_valid,
    input wire logic                  frame_done
);

    // requests accepted but not yet delivered
    logic [3:0] pending_reg;
    logic [3:0] pending_next;

    always_comb
    begin
        pending_next = pending_reg + 4'(in_valid && in_ready) - 4'(out_valid && out_ready);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg <= '0;
        end
        else
        begin
            pending_reg <= pending_next;
        end
    end

    // a stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(median)
            && $stable(window_valid) && $stable(frame_done))
        else $error("result changed while stalled");

    // border results carry a zero median
    a_border_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !window_valid |-> median == '0)
        else $error("nonzero median on border pixel");

    // no result without an outstanding request
    a_no_invent: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> pending_reg != 4'd0)
        else $error("result without a pending request");

    // pipeline holds at most five requests
    a_depth: assert property (@(posedge clk) disable iff (!rst_n)
        pending_reg <= 4'd5)
        else $error("too many requests in flight");

endmodule

bind median_filter_3x3 mfilt_checker #(
    .PIXEL_BITS (PIXEL_BITS)
) u_mfilt_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .median       (median),
    .window_valid (window_valid),
    .frame_done   (frame_done)
);

`default_nettype wire

// File: sim/median_filter_3x3_checker.sv
module median_filter_3x3_checker
    import mfilt_pkg::*;
#(
    parameter int MAX_WIDTH = 1024
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    input  logic                 in_ready,
    input  logic [7:0]           pixel,
    input  logic                 out_valid,
    input  logic                 out_ready,
    input  logic [7:0]           median,
    input  logic                 window_valid,
    input  logic                 frame_done,
    input  logic                 cfg_valid,
    input  logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data,
    output int                   mismatches,
    output int                   outstanding
);

    typedef struct packed {
        logic [7:0] median;
        logic       window_valid;
        logic       frame_done;
    } pixel_result_t;

    // line_mem[0] holds the most recent line
    logic [7:0]       line_mem [2][MAX_WIDTH];
    logic [7:0]       win [3][3];
    int unsigned      col_pos;
    int unsigned      row_pos;
    logic [CFG_W-1:0] width_reg;
    logic [CFG_W-1:0] height_reg;
    pixel_result_t    median_queue [$];

    function automatic int unsigned clamp_dim(input logic [CFG_W-1:0] v, input int unsigned hi);
        if (v == '0)
            return 1;
        if (v > hi)
            return hi;
        return 32'(v);
    endfunction

    function automatic logic [7:0] middle_of_window();
        logic [7:0] v [9];
        logic [7:0] t;
        int         r;
        int         c;
        for (r = 0; r < 3; r++)
            for (c = 0; c < 3; c++)
                v[3 * r + c] = win[r][c];
        for (r = 0; r < 8; r++)
            for (c = 0; c < 8 - r; c++)
                if (v[c] > v[c + 1])
                begin
                    t = v[c];
                    v[c] = v[c + 1];
                    v[c + 1] = t;
                end
        return v[4];
    endfunction

    function automatic pixel_result_t filter_next_pixel(input logic [7:0] px);
        pixel_result_t res;
        int unsigned   w;
        int unsigned   h;
        int unsigned   addr;
        logic [7:0]    incoming [3];
        int            r;
        w = clamp_dim(width_reg, MAX_WIDTH);
        h = clamp_dim(height_reg, HEIGHT_LIMIT);
        addr = col_pos % MAX_WIDTH;
        // oldest line on top, new pixel at the bottom
        incoming[0] = line_mem[1][addr];
        incoming[1] = line_mem[0][addr];
        incoming[2] = px;
        line_mem[1][addr] = line_mem[0][addr];
        line_mem[0][addr] = px;
        for (r = 0; r < 3; r++)
        begin
            win[r][0] = win[r][1];
            win[r][1] = win[r][2];
            win[r][2] = incoming[r];
        end
        res.window_valid = (col_pos >= 2) && (row_pos >= 2);
        res.median = res.window_valid ? middle_of_window() : 8'd0;
        res.frame_done = (col_pos + 1 >= w) && (row_pos + 1 >= h);
        if (col_pos + 1 >= w)
        begin
            col_pos = 0;
            row_pos = (row_pos + 1 >= h) ? 0 : row_pos + 1;
        end
        else
            col_pos = col_pos + 1;
        return res;
    endfunction

    always @(posedge clk)
    begin : watch
        int            bad;
        pixel_result_t want;
        bad = 0;
        if (!rst_n)
        begin
            for (int k = 0; k < MAX_WIDTH; k++)
            begin
                line_mem[0][k] = '0;
                line_mem[1][k] = '0;
            end
            for (int r = 0; r < 3; r++)
                for (int c = 0; c < 3; c++)
                    win[r][c] = '0;
            col_pos = 0;
            row_pos = 0;
            width_reg = WIDTH_RESET;
            height_reg = HEIGHT_RESET;
            median_queue.delete();
            mismatches <= 0;
            outstanding <= 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (mfilt_reg_e'(cfg_index))
                    REG_FRAME_WIDTH:  width_reg = cfg_data;
                    REG_FRAME_HEIGHT: height_reg = cfg_data;
                    default: ;
                endcase
            end
            if (in_valid && in_ready)
                median_queue.push_back(filter_next_pixel(pixel));
            if (out_valid && out_ready)
            begin
                if (median_queue.size() == 0)
                begin
                    $error("result with no pixel request pending: median %0d", median);
                    bad = bad + 1;
                end
                else
                begin
                    want = median_queue.pop_front();
                    if (median !== want.median)
                    begin
                        $error("median: expected %0d, got %0d", want.median, median);
                        bad = bad + 1;
                    end
                    if (window_valid !== want.window_valid)
                    begin
                        $error("window_valid: expected %0d, got %0d",
                               want.window_valid, window_valid);
                        bad = bad + 1;
                    end
                    if (frame_done !== want.frame_done)
                    begin
                        $error("frame_done: expected %0d, got %0d",
                               want.frame_done, frame_done);
                        bad = bad + 1;
                    end
                end
            end
            mismatches <= mismatches + bad;
            outstanding <= median_queue.size();
        end
    end

endmodule

// File: sim/median_filter_3x3_tb.sv
module median_filter_3x3_tb;
    import mfilt_pkg::*;

    // far beyond the slowest correct run of a few thousand pixel requests
    localparam int CYCLE_LIMIT   = 400000;
    localparam int RANDOM_PIXELS = 1750;
    localparam int MAX_WIDTH     = 1024;

    // how much each side of the stream idles during a phase
    typedef enum {
        IDLE_NONE,
        IDLE_SENDER,
        IDLE_RECEIVER,
        IDLE_BOTH
    } idle_mode_e;

    // image content of a phase
    typedef enum {
        TEXTURE_NOISE,
        TEXTURE_BINARY,
        TEXTURE_FLAT
    } texture_e;

    // frame geometry of a phase
    typedef enum {
        SHAPE_NORMAL,
        SHAPE_TINY,
        SHAPE_TALL,
        SHAPE_WIDE,
        SHAPE_FULL_ROW
    } shape_e;

    // directed 4x4 frame: rails, alternating rails, single-bit and near-rail values
    localparam logic [7:0] CORNER_PIXELS [16] = '{
        8'h00, 8'hFF, 8'h00, 8'hFF,
        8'hFF, 8'h00, 8'hFF, 8'h00,
        8'h55, 8'hAA, 8'h01, 8'h80,
        8'hFE, 8'h7F, 8'hFF, 8'hFF
    };

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 in_valid = 1'b0;
    logic                 in_ready;
    logic [7:0]           pixel = '0;
    logic                 out_valid;
    logic                 out_ready = 1'b0;
    logic [7:0]           median;
    logic                 window_valid;
    logic                 frame_done;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = REG_FRAME_WIDTH;
    logic [CFG_W-1:0]     cfg_data = '0;

    int                   mismatches;
    int                   outstanding;
    int                   cycle_count = 0;
    int                   sender_idle_pct = 0;
    int                   receiver_stall_pct = 0;
    // last width written, used to keep width growth at a frame start
    logic [CFG_W-1:0]     width_now = WIDTH_RESET;

    median_filter_3x3 dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .pixel        (pixel),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .median       (median),
        .window_valid (window_valid),
        .frame_done   (frame_done),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    median_filter_3x3_checker #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .pixel        (pixel),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .median       (median),
        .window_valid (window_valid),
        .frame_done   (frame_done),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .mismatches   (mismatches),
        .outstanding  (outstanding)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // watchdog against a hung handshake
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Verification failed");
            $finish;
        end
    end

    // result side backpressure, redrawn every cycle
    always @(posedge clk)
    begin
        out_ready <= ($urandom_range(99) >= receiver_stall_pct);
    end

    // effective row length after saturation to 1..MAX_WIDTH
    function automatic int unsigned usable_width(input logic [CFG_W-1:0] v);
        if (v == '0)
            return 1;
        if (v > MAX_WIDTH)
            return MAX_WIDTH;
        return 32'(v);
    endfunction

    function automatic logic [7:0] pick_pixel(input texture_e texture, input logic [7:0] base);
        case (texture)
            TEXTURE_BINARY: return $urandom_range(1) ? 8'hFF : 8'h00;
            // flat area with small noise, lots of ties; wraps near the rails
            TEXTURE_FLAT:   return base + 8'($urandom_range(6)) - 8'd3;
            default:        return 8'($urandom_range(255));
        endcase
    endfunction

    // one pixel request; valid stays up into the next request when there is no gap
    task automatic send_pixel(input logic [7:0] v);
        int gap;
        gap = 0;
        while ($urandom_range(99) < sender_idle_pct)
            gap++;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        pixel <= v;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
    endtask

    // drop valid and wait until every predicted result has come out
    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
    endtask

    // write both geometry registers; only called with the pipeline empty
    task automatic program_regs(input logic [CFG_W-1:0] w, input logic [CFG_W-1:0] h);
        cfg_valid <= 1'b1;
        cfg_index <= REG_FRAME_WIDTH;
        cfg_data <= w;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_index <= REG_FRAME_HEIGHT;
        cfg_data <= h;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        width_now = w;
    endtask

    // the line memory is never cleared, so a wider row must start at a frame start:
    // a 1x1 frame closes whatever frame is open, then the new geometry takes over
    task automatic apply_geometry(input logic [CFG_W-1:0] w, input logic [CFG_W-1:0] h);
        if (usable_width(w) > usable_width(width_now))
        begin
            program_regs('0, '0);
            send_pixel(8'($urandom_range(255)));
            drain();
        end
        program_regs(w, h);
    endtask

    initial
    begin : stimulus
        int               phase;
        int               roll;
        int               count;
        int               random_sent;
        shape_e           shape;
        texture_e         texture;
        logic [7:0]       base;
        logic [CFG_W-1:0] w;
        logic [CFG_W-1:0] h;

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: one small frame with rail and bit-pattern pixels
        program_regs(11'd4, 11'd4);
        foreach (CORNER_PIXELS[i])
            send_pixel(CORNER_PIXELS[i]);
        drain();

        // frame smaller than the window: no window ever valid
        program_regs(11'd2, 11'd2);
        send_pixel(8'hFF);
        send_pixel(8'h00);
        send_pixel(8'h80);
        send_pixel(8'h01);
        drain();

        // width zero and height above range both saturate
        program_regs(11'd0, 11'd2047);
        send_pixel(8'h00);
        send_pixel(8'hFF);
        send_pixel(8'h3C);
        drain();

        phase = 0;
        random_sent = 0;
        while (random_sent < RANDOM_PIXELS)
        begin
            case (idle_mode_e'(phase % 4))
                IDLE_SENDER:
                begin
                    sender_idle_pct = 55;
                    receiver_stall_pct = 0;
                end
                IDLE_RECEIVER:
                begin
                    sender_idle_pct = 0;
                    receiver_stall_pct = 55;
                end
                IDLE_BOTH:
                begin
                    sender_idle_pct = 19;
                    receiver_stall_pct = 19;
                end
                default:
                begin
                    sender_idle_pct = 0;
                    receiver_stall_pct = 0;
                end
            endcase

            // one phase runs a full MAX_WIDTH row so the column wraps at the memory end
            roll = $urandom_range(99);
            if (phase == 5)
                shape = SHAPE_FULL_ROW;
            else if (roll < 8)
                shape = SHAPE_TINY;
            else if (roll < 16)
                shape = SHAPE_TALL;
            else if (roll < 22)
                shape = SHAPE_WIDE;
            else
                shape = SHAPE_NORMAL;

            case (shape)
                SHAPE_FULL_ROW:
                begin
                    w = $urandom_range(1) ? 11'd1024 : 11'd2047;
                    h = 11'($urandom_range(1));
                    count = MAX_WIDTH;
                end
                SHAPE_TINY:
                begin
                    w = 11'($urandom_range(2));
                    h = 11'($urandom_range(6));
                    count = $urandom_range(3, 24);
                end
                SHAPE_TALL:
                begin
                    // partial frame; a later phase shrinks the height under the row count
                    w = 11'($urandom_range(3, 10));
                    h = $urandom_range(1) ? HEIGHT_LIMIT : 11'($urandom_range(1025, 2047));
                    count = $urandom_range(20, 60);
                end
                SHAPE_WIDE:
                begin
                    // a few pixels of a long row, cut short by the next geometry
                    w = 11'($urandom_range(900, 2047));
                    h = 11'($urandom_range(3, 2047));
                    count = $urandom_range(10, 40);
                end
                default:
                begin
                    w = 11'($urandom_range(3, 12));
                    h = 11'($urandom_range(3, 8));
                    count = w * h * $urandom_range(1, 2);
                    // sometimes stop mid-frame so the next geometry lands mid-frame
                    if ($urandom_range(3) == 0)
                        count = $urandom_range(1, w * h);
                end
            endcase

            apply_geometry(w, h);
            texture = texture_e'($urandom_range(2));
            base = 8'($urandom_range(255));
            repeat (count)
                send_pixel(pick_pixel(texture, base));
            random_sent += count;
            drain();
            phase++;
        end

        // let any stray result surface before the verdict
        receiver_stall_pct = 0;
        repeat (10) @(posedge clk);
        if (mismatches == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
